### hw/rtl/two_pool_bitmap_page_allocator_macros.svh
// ----------------------------------------------------------------------------
// two_pool_bitmap_page_allocator_macros
// assertion macros for the checker file of the allocator
// ----------------------------------------------------------------------------
`ifndef TWO_POOL_BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define TWO_POOL_BITMAP_PAGE_ALLOCATOR_MACROS_SVH

// property checked at every clock edge outside of reset
`define TPBA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every clock edge, reset included
`define TPBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/tpba_pkg.sv
// ----------------------------------------------------------------------------
// tpba_pkg
// shared types and constants of the two-pool bitmap page allocator
// ----------------------------------------------------------------------------
`default_nettype none

package tpba_pkg;

   localparam int ADDR_BITS          = 22;
   localparam int CNT_W              = 11;
   localparam int WORD_BITS          = 32;
   localparam int REQ_TDATA_W        = 24;
   localparam int REQ_TUSER_W        = 3;
   localparam int RSP_TDATA_W        = 24;
   localparam int RSP_TUSER_W        = 3;
   localparam int CSR_INDEX_W        = 2;
   localparam int DEF_MAX_POOL_PAGES = 1024;
   localparam int DEF_PAGE_BYTES     = 4096;

   typedef enum logic [1:0] {
      REQ_ALLOC,
      REQ_FREE,
      REQ_INIT
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_NOT_INIT,
      ST_NO_FREE,
      ST_RANGE,
      ST_MISALIGNED
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CODE_PAGE_COUNT,
      CSR_DATA_PAGE_COUNT,
      CSR_CODE_RESERVED,
      CSR_DATA_RESERVED
   } csr_index_type;

endpackage

`default_nettype wire

### hw/rtl/tpba_ram.sv
// ----------------------------------------------------------------------------
// tpba_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module tpba_ram
   import tpba_pkg::*;
#(
   parameter int WIDTH = WORD_BITS,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/two_pool_bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// two_pool_bitmap_page_allocator
// first-fit page allocator over used-page bitmaps for a code and a data pool
// ----------------------------------------------------------------------------
// Both bitmaps live in one ram, one 32-bit word per cycle through a single
// read port and a single write port. An alloc request scans at most
// ceil(page_count/32) bitmap words (32 at the default of 1024 pages). Init
// rewrites every word of the ram, one word a cycle; the ram needs no clearing
// pass after reset because nothing reads it before the first init. One
// request is worked on at a time; a new request is taken while the previous
// response still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module two_pool_bitmap_page_allocator
   import tpba_pkg::*;
#(
   parameter int MAX_POOL_PAGES = DEF_MAX_POOL_PAGES,
   parameter int PAGE_BYTES     = DEF_PAGE_BYTES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request: tdata = free_address[21:0]; tuser = req_type[1:0], pool[2]
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,
   // response: tdata = page_address[21:0]; tuser = status[2:0]
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,
   output logic      [RSP_TUSER_W-1:0] rsp_tuser,
   // configuration
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CNT_W-1:0]       csr_wdata
);

   localparam int POOL_WORDS = (MAX_POOL_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_W     = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;
   localparam int MEM_AW     = WORD_W + 1;
   localparam int MEM_DEPTH  = 2 << WORD_W;
   localparam int PB_LOG     = $clog2(PAGE_BYTES);
   localparam int IDX_W      = ADDR_BITS - PB_LOG;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT,
      S_SCAN,
      S_FREE_WR,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       found;
      logic [4:0] bit_idx;
   } hit_type;

   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n);
      if (32'(n) > 32'(MAX_POOL_PAGES)) begin
         return CNT_W'(MAX_POOL_PAGES);
      end
      return n;
   endfunction

   // ones for pages of this word that lie below lim
   function automatic logic [WORD_BITS-1:0] lead_mask(input logic [CNT_W-1:0] lim,
                                                      input logic [31:0] base);
      logic [31:0] rem;
      rem = 32'(lim) - base;
      if (32'(lim) <= base) begin
         return '0;
      end
      if (32'(lim) >= base + 32'(WORD_BITS)) begin
         return '1;
      end
      return (32'd1 << rem[4:0]) - 32'd1;
   endfunction

   function automatic hit_type lowest_set(input logic [WORD_BITS-1:0] v);
      hit_type h;
      h.found   = |v;
      h.bit_idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            h.bit_idx = 5'(i);
         end
      end
      return h;
   endfunction

   // configuration registers
   logic [CNT_W-1:0] code_count_ff, data_count_ff, code_res_ff, data_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_count_ff <= '0;
         data_count_ff <= '0;
         code_res_ff   <= '0;
         data_res_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CODE_PAGE_COUNT: code_count_ff <= csr_wdata;
            CSR_DATA_PAGE_COUNT: data_count_ff <= csr_wdata;
            CSR_CODE_RESERVED:   code_res_ff   <= csr_wdata;
            CSR_DATA_RESERVED:   data_res_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   state_type         state_ff, state_in;
   logic              initialized_ff, initialized_in;
   logic              pool_ff, pool_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [4:0]        bit_ff, bit_in;
   logic [MEM_AW-1:0] init_ff, init_in;
   status_type        res_status_ff, res_status_in;
   logic [ADDR_BITS-1:0] res_addr_ff, res_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [ADDR_BITS-1:0] rsp_addr_ff, rsp_addr_in;

   logic                 mem_wr_en, mem_rd_en;
   logic [MEM_AW-1:0]    mem_wr_addr, mem_rd_addr;
   logic [WORD_BITS-1:0] mem_wr_data, mem_rd_data;

   tpba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MEM_DEPTH)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   logic [CNT_W-1:0]     eff_code, eff_data, eff_req, eff_cur;
   logic [CNT_W-1:0]     code_lim, data_lim, init_lim, stack_page;
   logic                 req_pool;
   req_kind_type         req_kind;
   logic [ADDR_BITS-1:0] free_addr;
   logic [IDX_W-1:0]     free_idx;
   logic [WORD_W-1:0]    init_word_idx;
   logic [WORD_BITS-1:0] init_word, scan_cand;
   logic [31:0]          scan_base, init_base, words_used;
   hit_type              scan_hit;

   assign eff_code   = clamp_count(code_count_ff);
   assign eff_data   = clamp_count(data_count_ff);
   assign code_lim   = (code_res_ff < eff_code) ? code_res_ff : eff_code;
   assign data_lim   = (data_res_ff < eff_data) ? data_res_ff : eff_data;
   assign stack_page = eff_data - CNT_W'(1);

   assign req_kind  = req_kind_type'(req_tuser[1:0]);
   assign req_pool  = req_tuser[2];
   assign free_addr = req_tdata[ADDR_BITS-1:0];
   assign free_idx  = free_addr[ADDR_BITS-1:PB_LOG];
   assign eff_req   = req_pool ? eff_data : eff_code;
   assign eff_cur   = pool_ff ? eff_data : eff_code;

   // init word: leading reserved pages plus the stack page in the data pool
   assign init_word_idx = init_ff[WORD_W-1:0];
   assign init_base     = 32'(init_word_idx) << 5;
   assign init_lim      = init_ff[MEM_AW-1] ? data_lim : code_lim;

   always_comb begin
      init_word = lead_mask(init_lim, init_base);
      if (init_ff[MEM_AW-1] && (eff_data != '0) &&
          ((32'(stack_page) >> 5) == 32'(init_word_idx))) begin
         init_word[stack_page[4:0]] = 1'b1;
      end
   end

   assign scan_base  = 32'(word_ff) << 5;
   assign scan_cand  = ~mem_rd_data & lead_mask(eff_cur, scan_base);
   assign scan_hit   = lowest_set(scan_cand);
   assign words_used = (32'(eff_cur) + 32'(WORD_BITS - 1)) >> 5;

   always_comb begin
      state_in       = state_ff;
      initialized_in = initialized_ff;
      pool_in        = pool_ff;
      word_in        = word_ff;
      bit_in         = bit_ff;
      init_in        = init_ff;
      res_status_in  = res_status_ff;
      res_addr_in    = res_addr_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_addr_in    = rsp_addr_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = {pool_ff, word_ff};
      mem_wr_data    = mem_rd_data;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = {req_pool, WORD_W'(free_idx >> 5)};

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               pool_in     = req_pool;
               res_addr_in = '0;
               state_in    = S_DONE;
               case (req_kind)
                  REQ_ALLOC: begin
                     if (!initialized_ff) begin
                        res_status_in = ST_NOT_INIT;
                     end else if (eff_req == '0) begin
                        res_status_in = ST_NO_FREE;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = {req_pool, WORD_W'(0)};
                        word_in     = '0;
                        state_in    = S_SCAN;
                     end
                  end
                  REQ_FREE: begin
                     if (free_addr[PB_LOG-1:0] != '0) begin
                        res_status_in = ST_MISALIGNED;
                     end else if (!initialized_ff) begin
                        res_status_in = ST_NOT_INIT;
                     end else if (32'(free_idx) >= 32'(eff_req)) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        mem_rd_en = 1'b1;
                        word_in   = WORD_W'(free_idx >> 5);
                        bit_in    = free_idx[4:0];
                        state_in  = S_FREE_WR;
                     end
                  end
                  REQ_INIT: begin
                     init_in  = '0;
                     state_in = S_INIT;
                  end
                  default: begin
                     res_status_in = ST_RANGE;
                  end
               endcase
            end
         end
         S_INIT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = init_ff;
            mem_wr_data = init_word;
            if (init_ff == MEM_AW'(MEM_DEPTH - 1)) begin
               initialized_in = 1'b1;
               res_status_in  = ST_OK;
               state_in       = S_DONE;
            end else begin
               init_in = init_ff + MEM_AW'(1);
            end
         end
         S_SCAN: begin
            if (scan_hit.found) begin
               mem_wr_en     = 1'b1;
               mem_wr_data   = mem_rd_data | (WORD_BITS'(1) << scan_hit.bit_idx);
               res_status_in = ST_OK;
               res_addr_in   = ADDR_BITS'((scan_base | 32'(scan_hit.bit_idx)) << PB_LOG);
               state_in      = S_DONE;
            end else if (32'(word_ff) + 32'd1 >= words_used) begin
               res_status_in = ST_NO_FREE;
               state_in      = S_DONE;
            end else begin
               // next word read overlaps the check of this one
               mem_rd_en   = 1'b1;
               mem_rd_addr = {pool_ff, word_ff + WORD_W'(1)};
               word_in     = word_ff + WORD_W'(1);
            end
         end
         S_FREE_WR: begin
            mem_wr_en     = 1'b1;
            mem_wr_data   = mem_rd_data & ~(WORD_BITS'(1) << bit_ff);
            res_status_in = ST_OK;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         initialized_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         initialized_ff <= initialized_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      pool_ff       <= pool_in;
      word_ff       <= word_in;
      bit_ff        <= bit_in;
      init_ff       <= init_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_addr_ff);
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

### hw/rtl/tpba_checker.sv
// ----------------------------------------------------------------------------
// tpba_checker
// port-level checks of the page allocator response channel
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_pool_bitmap_page_allocator_macros.svh"

module tpba_checker
   import tpba_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [RSP_TUSER_W-1:0] rsp_tuser
);

   // stalled response holds
   `TPBA_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while stalled")

   // only a successful alloc carries an address
   `TPBA_ASSERT(a_addr_zero, clock, reset, rsp_tvalid && (rsp_tuser != ST_OK) |-> rsp_tdata == '0, "address on a failed response")

   `TPBA_ASSERT(a_status_known, clock, reset, rsp_tvalid |-> rsp_tuser <= ST_MISALIGNED, "unknown status code")

   // first cycle out of reset has no response
   `TPBA_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) && !reset |-> !rsp_tvalid, "response right after reset")

endmodule

bind two_pool_bitmap_page_allocator tpba_checker u_tpba_checker (.*);

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the two-pool bitmap page allocator: directed table
// then random traffic of all request kinds, each response compared to a typed
// reply or bitmap predictor, random gaps on both streams, one long rsp stall
// ----------------------------------------------------------------------------

module tb_top;
   import tpba_pkg::*;

   localparam int      LIMIT_CYCLES     = 400000;
   localparam int      RSP_STALL_CYCLES = 300;
   localparam int      TAIL_CYCLES      = 80;
   localparam int      PHASES           = 6;
   localparam int      ITEMS_PER_PHASE  = 88;
   localparam int      POOL_PAGES       = DEF_MAX_POOL_PAGES;
   localparam int      PAGE_STRIDE      = DEF_PAGE_BYTES;
   localparam int      LAST_INDEX       = (1 << ADDR_BITS) / PAGE_STRIDE - 1;
   localparam int      MAX_INDEX        = POOL_PAGES - 1 < LAST_INDEX ?
                                          POOL_PAGES - 1 : LAST_INDEX;
   localparam logic [1:0] REQ_UNKNOWN   = 2'd3;
   localparam logic    CODE             = 1'b0;
   localparam logic    DATA             = 1'b1;
   localparam logic    ROW_REQ          = 1'b0;
   localparam logic    ROW_CSR          = 1'b1;
   localparam logic    CALC             = 1'b0;
   localparam logic    KNOWN            = 1'b1;

   typedef struct packed {
      status_type           status;
      logic [ADDR_BITS-1:0] page_address;
   } page_reply_type;

   typedef struct packed {
      logic                 row_kind;
      csr_index_type        csr_sel;
      logic [CNT_W-1:0]     csr_value;
      logic [1:0]           req_kind;
      logic                 pool;
      logic [ADDR_BITS-1:0] address;
      logic                 known;
      status_type           status;
      logic [ADDR_BITS-1:0] page_address;
   } directed_step_type;

   // pool sizes change between rows, replies typed in where obvious
   localparam directed_step_type DIRECTED_STEPS [30] = '{
      '{ROW_REQ, CSR_CODE_PAGE_COUNT, 11'd0, REQ_ALLOC, CODE, 22'h0, KNOWN, ST_NOT_INIT, 22'h0},
      '{ROW_REQ, CSR_CODE_PAGE_COUNT, 11'd0, REQ_FREE, DATA, 22'h0, KNOWN, ST_NOT_INIT, 22'h0},
      '{ROW_REQ, CSR_CODE_PAGE_COUNT, 11'd0, REQ_FREE, CODE, 22'h3fffff, KNOWN, ST_MISALIGNED,
        22'h0},
      '{ROW_REQ, CSR_CODE_PAGE_COUNT, 11'd0, REQ_UNKNOWN, DATA, 22'h3fffff, KNOWN, ST_RANGE,
        22'h0},
      '{ROW_REQ, CSR_CODE_PAGE_COUNT, 11'd0, REQ_INIT, DATA, 22'h2aaaaa, KNOWN, ST_OK, 22'h0},
      '{ROW_REQ, CSR_CODE_PAGE_COUNT, 11'd0, REQ_ALLOC, CODE, 22'h155555, KNOWN, ST_NO_FREE,
        22'h0},
      '{ROW_REQ, CSR_CODE_PAGE_COUNT, 11'd0, REQ_FREE, DATA, 22'h0, KNOWN, ST_RANGE, 22'h0},
      '{ROW_CSR, CSR_CODE_PAGE_COUNT, 11'd1024, REQ_ALLOC, CODE, 22'h0, CALC, ST_OK, 22'h0},
      '{ROW_CSR, CSR_DATA_PAGE_COUNT, 11'd1024, REQ_ALLOC, CODE, 22'h0, CALC, ST_OK, 22'h0},
      '{ROW_CSR, CSR_CODE_RESERVED, 11'd2047, REQ_ALLOC, CODE, 22'h0, CALC, ST_OK, 22'h0},
      '{ROW_CSR, CSR_DATA_RESERVED, 11'd0, REQ_ALLOC, CODE, 22'h0, CALC, ST_OK, 22'h0},
      '{ROW_REQ, CSR_CODE_PAGE_COUNT, 11'd0, REQ_INIT, CODE, 22'h0, KNOWN, ST_OK, 22'h0},
      '{ROW_REQ, CSR_CODE_PAGE_COUNT, 11'd0, REQ_ALLOC, CODE, 22'h0, KNOWN, ST_NO_FREE, 22'h0},
      '{ROW_REQ, CSR_CODE_PAGE_COUNT, 11'd0, REQ_ALLOC, DATA, 22'h3fffff, KNOWN, ST_OK, 22'h0},
      '{ROW_REQ, CSR_CODE_PAGE_COUNT, 11'd0, REQ_FREE, DATA, 22'h3ff000, KNOWN, ST_OK, 22'h0},
      '{ROW_REQ, CSR_CODE_PAGE_COUNT, 11'd0, REQ_FREE, CODE, 22'h3ff000, KNOWN, ST_OK, 22'h0},
      '{ROW_REQ, CSR_CODE_PAGE_COUNT, 11'd0, REQ_ALLOC, CODE, 22'h0, CALC, ST_OK, 22'h0},
      '{ROW_REQ, CSR_CODE_PAGE_COUNT, 11'd0, REQ_ALLOC, DATA, 22'h0, CALC, ST_OK, 22'h0},
      '{ROW_CSR, CSR_DATA_PAGE_COUNT, 11'd2047, REQ_ALLOC, CODE, 22'h0, CALC, ST_OK, 22'h0},
      '{ROW_REQ, CSR_CODE_PAGE_COUNT, 11'd0, REQ_ALLOC, DATA, 22'h0, CALC, ST_OK, 22'h0},
      '{ROW_CSR, CSR_DATA_PAGE_COUNT, 11'd1, REQ_ALLOC, CODE, 22'h0, CALC, ST_OK, 22'h0},
      '{ROW_REQ, CSR_CODE_PAGE_COUNT, 11'd0, REQ_INIT, CODE, 22'h0, KNOWN, ST_OK, 22'h0},
      '{ROW_REQ, CSR_CODE_PAGE_COUNT, 11'd0, REQ_ALLOC, DATA, 22'h0, KNOWN, ST_NO_FREE, 22'h0},
      '{ROW_REQ, CSR_CODE_PAGE_COUNT, 11'd0, REQ_FREE, DATA, 22'h001000, KNOWN, ST_RANGE,
        22'h0},
      '{ROW_REQ, CSR_CODE_PAGE_COUNT, 11'd0, REQ_FREE, DATA, 22'h0, KNOWN, ST_OK, 22'h0},
      '{ROW_REQ, CSR_CODE_PAGE_COUNT, 11'd0, REQ_ALLOC, DATA, 22'h0, KNOWN, ST_OK, 22'h0},
      '{ROW_CSR, CSR_DATA_PAGE_COUNT, 11'd0, REQ_ALLOC, CODE, 22'h0, CALC, ST_OK, 22'h0},
      '{ROW_REQ, CSR_CODE_PAGE_COUNT, 11'd0, REQ_INIT, DATA, 22'h0, KNOWN, ST_OK, 22'h0},
      '{ROW_REQ, CSR_CODE_PAGE_COUNT, 11'd0, REQ_ALLOC, DATA, 22'h0, KNOWN, ST_NO_FREE, 22'h0},
      '{ROW_REQ, CSR_CODE_PAGE_COUNT, 11'd0, REQ_FREE, DATA, 22'h000800, KNOWN, ST_MISALIGNED,
        22'h0}
   };

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CNT_W-1:0]       csr_wdata  = '0;

   // predictor state
   logic                   page_used [2][POOL_PAGES];
   logic                   pools_ready = 1'b0;
   logic [CNT_W-1:0]       pool_regs [4] = '{default: '0};

   page_reply_type         page_replies_due [$];
   int                     mismatch_count = 0;
   int                     cycle_count    = 0;
   int                     accepted_count = 0;
   int                     rsp_gap        = 0;
   logic                   rsp_stalled    = 1'b0;
   logic                   quiet_recv     = 1'b0;
   logic                   quiet_send     = 1'b0;

   two_pool_bitmap_page_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pool_limit(input logic pool);
      int n;
      n = pool ? int'(pool_regs[CSR_DATA_PAGE_COUNT]) : int'(pool_regs[CSR_CODE_PAGE_COUNT]);
      return n > POOL_PAGES ? POOL_PAGES : n;
   endfunction

   function automatic void mark_leading(input logic pool, input int reserved);
      int lim;
      lim = reserved < pool_limit(pool) ? reserved : pool_limit(pool);
      for (int i = 0; i < lim; i++) page_used[pool][i] = 1'b1;
   endfunction

   // updates the bitmaps as the allocator would and returns its reply
   function automatic page_reply_type apply_page_request(input logic [1:0] kind,
                                                         input logic pool,
                                                         input logic [ADDR_BITS-1:0] addr);
      page_reply_type reply;
      int             limit;
      int             idx;
      reply.status       = ST_OK;
      reply.page_address = '0;
      limit = pool_limit(pool);
      case (kind)
         REQ_ALLOC: begin
            if (!pools_ready) begin
               reply.status = ST_NOT_INIT;
            end else begin
               idx = 0;
               while (idx < limit && page_used[pool][idx]) idx++;
               if (idx < limit) begin
                  page_used[pool][idx] = 1'b1;
                  reply.page_address   = ADDR_BITS'(idx * PAGE_STRIDE);
               end else begin
                  reply.status = ST_NO_FREE;
               end
            end
         end
         REQ_FREE: begin
            // alignment is checked before the init flag
            if (addr % PAGE_STRIDE != 0) begin
               reply.status = ST_MISALIGNED;
            end else if (!pools_ready) begin
               reply.status = ST_NOT_INIT;
            end else begin
               idx = int'(addr) / PAGE_STRIDE;
               if (idx < limit) page_used[pool][idx] = 1'b0;
               else reply.status = ST_RANGE;
            end
         end
         REQ_INIT: begin
            foreach (page_used[p, i]) page_used[p][i] = 1'b0;
            mark_leading(DATA, int'(pool_regs[CSR_DATA_RESERVED]));
            // stack page at the top of the data pool
            if (pool_limit(DATA) > 0) page_used[DATA][pool_limit(DATA) - 1] = 1'b1;
            mark_leading(CODE, int'(pool_regs[CSR_CODE_RESERVED]));
            pools_ready = 1'b1;
         end
         default: begin
            reply.status = ST_RANGE;
         end
      endcase
      return reply;
   endfunction

   task automatic send_request(input logic [1:0] kind, input logic pool,
                               input logic [ADDR_BITS-1:0] addr, input logic known,
                               input status_type known_status,
                               input logic [ADDR_BITS-1:0] known_page);
      int             gap;
      page_reply_type reply;
      gap = quiet_send ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'(addr);
      req_tuser  <= {pool, kind};
      do @(posedge clock); while (!req_tready);
      reply = apply_page_request(kind, pool, addr);
      if (known) begin
         reply.status       = known_status;
         reply.page_address = known_page;
      end
      page_replies_due.push_back(reply);
      accepted_count++;
   endtask

   // registers only change with nothing in flight
   task automatic csr_write(input csr_index_type sel, input logic [CNT_W-1:0] value);
      @(negedge clock) req_tvalid <= 1'b0;
      while (page_replies_due.size() != 0) @(negedge clock);
      @(negedge clock);
      csr_we         <= 1'b1;
      csr_index      <= sel;
      csr_wdata      <= value;
      pool_regs[sel]  = value;
      @(negedge clock) csr_we <= 1'b0;
   endtask

   task automatic send_random_request();
      logic [1:0]           kind;
      logic                 pool;
      logic [ADDR_BITS-1:0] addr;
      int                   pick;
      int                   idx;
      pool = 1'($urandom_range(0, 1));
      addr = ADDR_BITS'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         kind = REQ_ALLOC;
      end else if (pick < 80) begin
         // mostly pages inside the pool, a few just past its end
         kind = REQ_FREE;
         idx  = $urandom_range(0, pool_limit(pool) + 1);
         if (idx > MAX_INDEX) idx = MAX_INDEX;
         addr = ADDR_BITS'(idx * PAGE_STRIDE);
      end else if (pick < 87) begin
         kind = REQ_FREE;
      end else if (pick < 92) begin
         kind = REQ_INIT;
      end else if (pick < 95) begin
         kind = REQ_UNKNOWN;
      end else begin
         kind = REQ_FREE;
         addr = ADDR_BITS'($urandom_range(0, MAX_INDEX) * PAGE_STRIDE);
      end
      send_request(kind, pool, addr, CALC, ST_OK, '0);
   endtask

   // response side: random ready gaps, plus one long hold
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap--;
      end else begin
         rsp_tready <= !rsp_stalled && !reset;
      end
   end

   initial begin
      wait (accepted_count >= 60);
      @(posedge clock) rsp_stalled = 1'b1;
      repeat (RSP_STALL_CYCLES) @(posedge clock);
      rsp_stalled = 1'b0;
   end

   always @(posedge clock) begin
      page_reply_type due;
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("[two_pool_bitmap_page_allocator] ERROR");
         $finish;
      end else if (!reset && rsp_tvalid && rsp_tready) begin
         if (page_replies_due.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual status %0d page %h",
                     $time, rsp_tuser, rsp_tdata);
            mismatch_count++;
         end else begin
            due = page_replies_due.pop_front();
            if (rsp_tuser !== RSP_TUSER_W'(due.status)) begin
               $display("%0t: status mismatch: expected %0d actual %0d",
                        $time, due.status, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tdata !== RSP_TDATA_W'(due.page_address)) begin
               $display("%0t: page address mismatch: expected %h actual %h",
                        $time, due.page_address, rsp_tdata);
               mismatch_count++;
            end
         end
         if ($urandom_range(0, 39) == 0) quiet_recv = !quiet_recv;
         rsp_gap = quiet_recv ? 0 : $urandom_range(0, 6);
      end
   end

   initial begin
      logic [CNT_W-1:0] code_cnt;
      logic [CNT_W-1:0] data_cnt;
      logic [CNT_W-1:0] code_res;
      logic [CNT_W-1:0] data_res;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_STEPS[n]) begin
         if (DIRECTED_STEPS[n].row_kind == ROW_CSR) begin
            csr_write(DIRECTED_STEPS[n].csr_sel, DIRECTED_STEPS[n].csr_value);
         end else begin
            send_request(DIRECTED_STEPS[n].req_kind, DIRECTED_STEPS[n].pool,
                         DIRECTED_STEPS[n].address, DIRECTED_STEPS[n].known,
                         DIRECTED_STEPS[n].status, DIRECTED_STEPS[n].page_address);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               code_cnt = 11'd1024;
               data_cnt = 11'd1024;
               code_res = CNT_W'($urandom_range(0, 40));
               data_res = CNT_W'($urandom_range(0, 40));
            end
            1: begin
               // long scans: code fully reserved, data nearly full
               code_cnt = 11'd2047;
               data_cnt = 11'd2047;
               code_res = 11'd2047;
               data_res = 11'd1000;
            end
            2: begin
               code_cnt = CNT_W'($urandom_range(1, 40));
               data_cnt = CNT_W'($urandom_range(1, 40));
               code_res = CNT_W'($urandom_range(0, 10));
               data_res = CNT_W'($urandom_range(0, 10));
            end
            3: begin
               code_cnt = CNT_W'($urandom_range(0, 12));
               data_cnt = CNT_W'($urandom_range(0, 12));
               code_res = CNT_W'($urandom_range(0, 15));
               data_res = CNT_W'($urandom_range(0, 15));
            end
            4: begin
               code_cnt = CNT_W'($urandom_range(0, 2047));
               data_cnt = CNT_W'($urandom_range(0, 2047));
               code_res = CNT_W'($urandom_range(0, 2047));
               data_res = CNT_W'($urandom_range(0, 2047));
            end
            default: begin
               code_cnt = 11'd1;
               data_cnt = 11'd2;
               code_res = 11'd0;
               data_res = 11'd0;
            end
         endcase
         csr_write(CSR_CODE_PAGE_COUNT, code_cnt);
         csr_write(CSR_DATA_PAGE_COUNT, data_cnt);
         csr_write(CSR_CODE_RESERVED, code_res);
         csr_write(CSR_DATA_RESERVED, data_res);
         // sometimes keep the old bitmaps so the new counts apply live
         if (phase == 0 || $urandom_range(0, 3) != 0) begin
            send_request(REQ_INIT, 1'($urandom_range(0, 1)), ADDR_BITS'($urandom), CALC,
                         ST_OK, '0);
         end
         for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
            if ($urandom_range(0, 29) == 0) quiet_send = !quiet_send;
            send_random_request();
         end
      end

      @(negedge clock) req_tvalid <= 1'b0;
      while (page_replies_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[two_pool_bitmap_page_allocator] OK");
      end else begin
         $display("[two_pool_bitmap_page_allocator] ERROR");
      end
      $finish;
   end

endmodule
